### hw/rtl/spsd_pkg.sv
// Shared constants for the segment pair squared distance block.
// Holds output and epsilon widths and the endpoint term selection tables.
// No dependencies.
package spsd_pkg;

  localparam int OUT_WIDTH = 50;
  localparam int EPS_WIDTH = 16;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd7;
  localparam logic [OUT_WIDTH-1:0] OUT_MAX = '1;

  // Squared vector lengths, in the order they are kept in the pipeline.
  localparam int SQ_PP = 0;
  localparam int SQ_PQ = 1;
  localparam int SQ_QP = 2;
  localparam int SQ_QQ = 3;

  // Source vector of each squared length: pp, pq, qp (as its negation), qq.
  localparam int SQ_SRC [0:3] = '{0, 1, 3, 4};

  // Endpoint that each projection is clamped to before the start and past the end.
  localparam int NEAR_SQ [0:3] = '{SQ_PP, SQ_PQ, SQ_PP, SQ_QP};
  localparam int FAR_SQ  [0:3] = '{SQ_QP, SQ_QQ, SQ_PQ, SQ_QQ};

endpackage

### hw/rtl/segment_pair_squared_distance.sv
// Top level of the segment pair squared distance pipeline.
// Depends on spsd_pkg; holds the divider lanes and all arithmetic stages.
//
// Usage. An item (two segments, each as start point, end point and length)
// is transferred at a rising edge where start is high and busy is low. busy
// is always low: the pipeline takes a new item in every cycle, so throughput
// is one item per clock. The result squared_distance is shown for exactly
// one cycle with done high; the receiver cannot stall, so nothing inside
// the pipeline ever waits.
// Most of the pipeline is the four restoring divider lanes that form the
// unit direction components, one quotient bit per stage; the remaining
// stages hold the coordinate differences, the projection products, the
// crossing test products and the final minimum.
// The epsilon register is written with cfg_we and cfg_wdata; it should only
// change while no item is in flight. Reset sets epsilon to 7 and clears all
// valid bits, so no done strobe appears for items in flight at reset.
module segment_pair_squared_distance #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       a_start_x,
  input  logic signed [COORD_WIDTH-1:0]       a_start_y,
  input  logic signed [COORD_WIDTH-1:0]       a_end_x,
  input  logic signed [COORD_WIDTH-1:0]       a_end_y,
  input  logic        [COORD_WIDTH:0]         a_length,
  input  logic signed [COORD_WIDTH-1:0]       b_start_x,
  input  logic signed [COORD_WIDTH-1:0]       b_start_y,
  input  logic signed [COORD_WIDTH-1:0]       b_end_x,
  input  logic signed [COORD_WIDTH-1:0]       b_end_y,
  input  logic        [COORD_WIDTH:0]         b_length,
  input  logic                                cfg_we,
  input  logic        [spsd_pkg::EPS_WIDTH-1:0] cfg_wdata,
  output logic                                done,
  output logic        [spsd_pkg::OUT_WIDTH-1:0] squared_distance
);
  import spsd_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int LW  = COORD_WIDTH + 1;   // lengths
  localparam int DW  = COORD_WIDTH + 1;   // coordinate differences
  localparam int UW  = F + 2;             // unit direction components
  localparam int PW  = UW + DW;           // direction times difference
  localparam int SW  = PW + 1 - F;        // along-line and normal offsets
  localparam int HW  = SW + 1;            // crossing denominators
  localparam int NW  = 2 * SW + 1;        // crossing numerators
  localparam int LMW = LW + HW + 1;       // length times denominator
  localparam int CMW = (NW > LMW ? NW : LMW) + 1;
  localparam int SQA = 2 * DW + 1;
  localparam int SQB = 2 * SW;
  localparam int SQC = F + OUT_WIDTH + 1;
  localparam int SQAB = SQA > SQB ? SQA : SQB;
  localparam int SQW = SQAB > SQC ? SQAB : SQC;

  function automatic logic [OUT_WIDTH-1:0] sat_floor(input logic [SQW-1:0] v);
    logic [SQW-1:0] sh;
    sh = v >> F;
    if (sh > SQW'(OUT_MAX)) begin
      sat_floor = OUT_MAX;
    end else begin
      sat_floor = sh[OUT_WIDTH-1:0];
    end
  endfunction

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Tolerance register.
  logic [EPS_WIDTH-1:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      epsilon <= cfg_wdata;
    end
  end

  // Stage A: coordinate differences. The divider lanes take the two
  // segment spans; the projections use P1->P2, P1->Q2, P2->P1, P2->Q1 and
  // Q1->Q2 (the last one only for its squared length).
  logic                 a_vld;
  logic signed [DW-1:0] a_dd  [0:3];
  logic signed [DW-1:0] a_vec [0:4][0:1];
  logic        [LW-1:0] a_len [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
  end

  always_ff @(posedge clk) begin
    a_dd[0]     <= DW'(a_end_x) - DW'(a_start_x);
    a_dd[1]     <= DW'(a_end_y) - DW'(a_start_y);
    a_dd[2]     <= DW'(b_end_x) - DW'(b_start_x);
    a_dd[3]     <= DW'(b_end_y) - DW'(b_start_y);
    a_vec[0][0] <= DW'(b_start_x) - DW'(a_start_x);
    a_vec[0][1] <= DW'(b_start_y) - DW'(a_start_y);
    a_vec[1][0] <= DW'(b_end_x) - DW'(a_start_x);
    a_vec[1][1] <= DW'(b_end_y) - DW'(a_start_y);
    a_vec[2][0] <= DW'(a_start_x) - DW'(b_start_x);
    a_vec[2][1] <= DW'(a_start_y) - DW'(b_start_y);
    a_vec[3][0] <= DW'(a_end_x) - DW'(b_start_x);
    a_vec[3][1] <= DW'(a_end_y) - DW'(b_start_y);
    a_vec[4][0] <= DW'(b_end_x) - DW'(a_end_x);
    a_vec[4][1] <= DW'(b_end_y) - DW'(a_end_y);
    a_len[0]    <= a_length;
    a_len[1]    <= b_length;
  end

  // Divider lanes: stage 0 sorts out zero length and saturation, then each
  // of the F stages below it produces one quotient bit of |D| / L.
  logic                 div_vld [0:F];
  logic        [LW-1:0] div_rem [0:F][0:3];
  logic        [F:0]    div_q   [0:F][0:3];
  logic                 div_fin [0:F][0:3];
  logic                 div_neg [0:F][0:3];
  logic signed [DW-1:0] div_vec [0:F][0:4][0:1];
  logic        [LW-1:0] div_len [0:F][0:1];

  logic        [LW-1:0] init_mag [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      init_mag[l] = a_dd[l][DW-1] ? LW'(-a_dd[l]) : LW'(a_dd[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else begin
      div_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 4; l++) begin
      div_neg[0][l] <= a_dd[l][DW-1];
      div_rem[0][l] <= init_mag[l];
      if (a_len[l >> 1] == '0) begin
        div_fin[0][l] <= 1'b1;
        div_q[0][l]   <= '0;
      end else if (init_mag[l] >= a_len[l >> 1]) begin
        div_fin[0][l] <= 1'b1;
        div_q[0][l]   <= (F+1)'(1) << F;
      end else begin
        div_fin[0][l] <= 1'b0;
        div_q[0][l]   <= '0;
      end
    end
    div_vec[0] <= a_vec;
    div_len[0] <= a_len;
  end

  for (genvar k = 1; k <= F; k++) begin : g_div
    logic [LW:0] r2 [0:3];
    logic        ge [0:3];

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        r2[l] = {div_rem[k-1][l], 1'b0};
        ge[l] = r2[l] >= {1'b0, div_len[k-1][l >> 1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[k] <= 1'b0;
      end else begin
        div_vld[k] <= div_vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < 4; l++) begin
        div_fin[k][l] <= div_fin[k-1][l];
        div_neg[k][l] <= div_neg[k-1][l];
        if (div_fin[k-1][l]) begin
          div_q[k][l]   <= div_q[k-1][l];
          div_rem[k][l] <= div_rem[k-1][l];
        end else begin
          div_q[k][l]   <= {div_q[k-1][l][F-1:0], ge[l]};
          div_rem[k][l] <= ge[l] ? LW'(r2[l] - {1'b0, div_len[k-1][l >> 1]})
                                 : LW'(r2[l]);
        end
      end
      div_vec[k] <= div_vec[k-1];
      div_len[k] <= div_len[k-1];
    end
  end

  // M1: projection products and squared vector components.
  logic signed [UW-1:0] dir [0:3];

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      dir[l] = div_neg[F][l] ? -$signed(UW'(div_q[F][l])) : $signed(UW'(div_q[F][l]));
    end
  end

  logic                   m1_vld;
  logic signed [PW-1:0]   m1_pa [0:3];
  logic signed [PW-1:0]   m1_pb [0:3];
  logic signed [PW-1:0]   m1_pc [0:3];
  logic signed [PW-1:0]   m1_pd [0:3];
  logic signed [2*DW-1:0] m1_sqx [0:3];
  logic signed [2*DW-1:0] m1_sqy [0:3];
  logic        [LW-1:0]   m1_len [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= div_vld[F];
    end
  end

  // Pairs 0 and 1 use segment A's direction, pairs 2 and 3 use segment B's.
  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      m1_pa[p]  <= dir[(p >> 1) * 2]     * div_vec[F][p][0];
      m1_pb[p]  <= dir[(p >> 1) * 2 + 1] * div_vec[F][p][1];
      m1_pc[p]  <= dir[(p >> 1) * 2]     * div_vec[F][p][1];
      m1_pd[p]  <= dir[(p >> 1) * 2 + 1] * div_vec[F][p][0];
      m1_sqx[p] <= div_vec[F][SQ_SRC[p]][0] * div_vec[F][SQ_SRC[p]][0];
      m1_sqy[p] <= div_vec[F][SQ_SRC[p]][1] * div_vec[F][SQ_SRC[p]][1];
    end
    m1_len <= div_len[F];
  end

  // M2: along-line offset s and normal offset h, floored; squared lengths.
  logic                   m2_vld;
  logic signed [SW-1:0]   m2_s   [0:3];
  logic signed [SW-1:0]   m2_h   [0:3];
  logic [OUT_WIDTH-1:0]   m2_sqm [0:3];
  logic        [LW-1:0]   m2_len [0:1];
  logic signed [PW:0]     sum_s  [0:3];
  logic signed [PW:0]     sum_h  [0:3];
  logic        [2*DW:0]   sum_sq [0:3];

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      sum_s[p]  = {m1_pa[p][PW-1], m1_pa[p]} + {m1_pb[p][PW-1], m1_pb[p]};
      sum_h[p]  = {m1_pc[p][PW-1], m1_pc[p]} - {m1_pd[p][PW-1], m1_pd[p]};
      sum_sq[p] = {1'b0, m1_sqx[p]} + {1'b0, m1_sqy[p]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      m2_s[p]   <= sum_s[p][PW:F];
      m2_h[p]   <= sum_h[p][PW:F];
      m2_sqm[p] <= sat_floor(SQW'(sum_sq[p]));
    end
    m2_len <= m1_len;
  end

  // M3: crossing denominators and numerator products, squared normal
  // offsets and the clamp decisions for each projection.
  logic                   m3_vld;
  logic signed [HW-1:0]   m3_den [0:1];
  logic signed [2*SW-1:0] m3_na  [0:1];
  logic signed [2*SW-1:0] m3_nb  [0:1];
  logic signed [2*SW-1:0] m3_hsq [0:3];
  logic                   m3_lt  [0:3];
  logic                   m3_gt  [0:3];
  logic [OUT_WIDTH-1:0]   m3_sqm [0:3];
  logic        [LW-1:0]   m3_len [0:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else begin
      m3_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 2; g++) begin
      m3_den[g] <= {m2_h[2*g][SW-1], m2_h[2*g]} - {m2_h[2*g+1][SW-1], m2_h[2*g+1]};
      m3_na[g]  <= m2_s[2*g+1] * m2_h[2*g];
      m3_nb[g]  <= m2_s[2*g] * m2_h[2*g+1];
    end
    for (int p = 0; p < 4; p++) begin
      m3_hsq[p] <= m2_h[p] * m2_h[p];
      m3_lt[p]  <= m2_s[p][SW-1];
      m3_gt[p]  <= m2_s[p] > $signed({{(SW-LW){1'b0}}, m2_len[p >> 1]});
    end
    m3_sqm <= m2_sqm;
    m3_len <= m2_len;
  end

  // M4: numerators, length times denominator, epsilon test and the four
  // endpoint-to-segment terms.
  logic                  m4_vld;
  logic signed [NW-1:0]  m4_num [0:1];
  logic signed [LMW-1:0] m4_lim [0:1];
  logic                  m4_pos [0:1];
  logic                  m4_eps_ok;
  logic [OUT_WIDTH-1:0]  m4_term [0:3];
  logic        [HW-1:0]  den_mag [0:1];

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      den_mag[g] = m3_den[g][HW-1] ? HW'(-m3_den[g]) : HW'(m3_den[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_vld <= 1'b0;
    end else begin
      m4_vld <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < 2; g++) begin
      m4_num[g] <= NW'(m3_na[g]) - NW'(m3_nb[g]);
      m4_lim[g] <= $signed({1'b0, m3_len[g]}) * m3_den[g];
      m4_pos[g] <= !m3_den[g][HW-1] && (m3_den[g] != '0);
    end
    m4_eps_ok <= (den_mag[0] > HW'(epsilon)) && (den_mag[1] > HW'(epsilon));
    for (int p = 0; p < 4; p++) begin
      if (m3_lt[p]) begin
        m4_term[p] <= m3_sqm[NEAR_SQ[p]];
      end else if (m3_gt[p]) begin
        m4_term[p] <= m3_sqm[FAR_SQ[p]];
      end else begin
        m4_term[p] <= sat_floor(SQW'(unsigned'(m3_hsq[p])));
      end
    end
  end

  // M5: crossing parameter range checks and the first level of the minimum.
  logic                  m5_vld;
  logic                  m5_cross;
  logic [OUT_WIDTH-1:0]  m5_min [0:1];
  logic signed [CMW-1:0] num_x  [0:1];
  logic signed [CMW-1:0] lim_x  [0:1];
  logic                  span_ok [0:1];

  // With a negative denominator the numerator must lie between the limit
  // and zero, so its sign bit or an all-zero value stands for num <= 0.
  always_comb begin
    for (int g = 0; g < 2; g++) begin
      num_x[g] = CMW'(m4_num[g]);
      lim_x[g] = CMW'(m4_lim[g]);
      if (m4_pos[g]) begin
        span_ok[g] = !num_x[g][CMW-1] && (num_x[g] <= lim_x[g]);
      end else begin
        span_ok[g] = (num_x[g][CMW-1] || (num_x[g] == '0)) && (num_x[g] >= lim_x[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_vld <= 1'b0;
    end else begin
      m5_vld <= m4_vld;
    end
  end

  always_ff @(posedge clk) begin
    m5_cross  <= m4_eps_ok && span_ok[0] && span_ok[1];
    m5_min[0] <= (m4_term[1] < m4_term[0]) ? m4_term[1] : m4_term[0];
    m5_min[1] <= (m4_term[3] < m4_term[2]) ? m4_term[3] : m4_term[2];
  end

  // M6: result register; a crossing pair reports zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m5_cross) begin
      squared_distance <= '0;
    end else begin
      squared_distance <= (m5_min[1] < m5_min[0]) ? m5_min[1] : m5_min[0];
    end
  end

endmodule

### hw/rtl/spsd_checker.sv
// Port-level checks for segment_pair_squared_distance, bound to the top level.
// Depends on spsd_pkg for the output width.
module spsd_checker #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic signed [COORD_WIDTH-1:0]        a_start_x,
  input logic signed [COORD_WIDTH-1:0]        a_start_y,
  input logic signed [COORD_WIDTH-1:0]        b_start_x,
  input logic signed [COORD_WIDTH-1:0]        b_start_y,
  input logic                                 done,
  input logic        [spsd_pkg::OUT_WIDTH-1:0] squared_distance
);
  import spsd_pkg::*;

  localparam int LATENCY = FRAC_BITS + 8;

  // Reset flushes every item in flight.
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("done strobe right after reset");

  // Every transfer yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after pipeline latency");

  // No result without a transfer at the matching earlier edge.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done strobe without a matching transfer");

  // Segments that share their start point are at distance zero.
  a_shared_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (a_start_x == b_start_x) && (a_start_y == b_start_y))
      |-> ##LATENCY (squared_distance == '0))
    else $error("shared start point gave a nonzero distance");

endmodule

bind segment_pair_squared_distance spsd_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_spsd_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .a_start_x        (a_start_x),
  .a_start_y        (a_start_y),
  .b_start_x        (b_start_x),
  .b_start_y        (b_start_y),
  .done             (done),
  .squared_distance (squared_distance)
);
